FILE: rtl/smcd_pkg.sv
package smcd_pkg;

   // Result operation codes
   localparam logic [2:0] OP_NONE       = 3'd0;
   localparam logic [2:0] OP_READ       = 3'd1;
   localparam logic [2:0] OP_WRITE      = 3'd2;
   localparam logic [2:0] OP_PAGE_WRITE = 3'd3;
   localparam logic [2:0] OP_ERASE      = 3'd4;
   localparam logic [2:0] OP_DUMP       = 3'd5;
   localparam logic [2:0] OP_INVALID    = 3'd6;

   // Job kinds passed from the parser to the result sequencer
   localparam logic [1:0] JOB_SINGLE = 2'd0;
   localparam logic [1:0] JOB_PAIR   = 2'd1;
   localparam logic [1:0] JOB_FLUSH  = 2'd2;

   localparam int QUEUE_DEPTH = 4;

   // For a flush job: address is the first page address, count the number of
   // gathered bytes, data the page offset of the first byte, reply the ack.
   typedef struct packed {
      logic [1:0]  job;
      logic [2:0]  op;
      logic [15:0] address;
      logic [7:0]  data;
      logic [15:0] count;
      logic [7:0]  reply;
   } job_type;

endpackage

FILE: rtl/serial_memory_command_decoder_core.sv
// Serial memory command decoder.
// Input queue side: one host byte per item (req_rx_byte) with the host
// backlog count (req_rx_backlog); an item enters when push is high and full
// is low. Result queue side: memory operations and reply bytes; the oldest
// result is on the rsp_ ports while empty is low and leaves when pop is high.
// rsp_last marks the final result caused by one input byte.
// The parser takes a byte in one cycle while full is low and hands at most
// one job to a four-entry job queue; the result sequencer drains it. A result
// passes the job queue, then the result register. Single and paired results
// leave one a cycle while pop is high; a page flush hands out each result
// by a page store read, then the result register, before its next read, and
// input is held off until the flush has been handed out. The page offset
// of the load address comes from a reciprocal multiply, registered as a
// quotient, then as the offset, before the count bytes are in, so load data
// never waits on it. A stalled result holds its register; the job queue keeps
// the parser taking bytes until it fills. Reset returns the parser to idle,
// empties both queues and sets erase_key to 0xBEEF. The page store needs no
// clearing. erase_key lies at byte address 0 of the register port.
module serial_memory_command_decoder_core #(
   parameter int PAGE_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_rx_backlog,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_op,
   output logic [15:0] rsp_mem_address,
   output logic [7:0]  rsp_mem_data,
   output logic [15:0] rsp_dump_count,
   output logic        rsp_reply_valid,
   output logic [7:0]  rsp_reply_byte,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   import smcd_pkg::*;

   localparam int IW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;

   localparam logic        REG_ERASE_KEY   = 1'b0;
   localparam logic [15:0] ERASE_KEY_RESET = 16'hBEEF;

   logic [15:0]   erase_key_ff;
   logic          csr_write;

   logic          q_push, q_pop, q_full, q_empty;
   job_type       q_wdata, q_rdata;
   logic          ram_we, ram_re;
   logic [IW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;
   logic          flush_done, flush_pend;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == REG_ERASE_KEY);
   assign prdata    = (paddr[2] == REG_ERASE_KEY) ? {16'd0, erase_key_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         erase_key_ff <= ERASE_KEY_RESET;
      end else if (csr_write) begin
         erase_key_ff <= pwdata[15:0];
      end
   end

   smcd_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .rx_byte    (req_rx_byte),
      .rx_backlog (req_rx_backlog),
      .erase_key  (erase_key_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_wdata),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .flush_done (flush_done),
      .flush_pend (flush_pend)
   );

   smcd_fifo u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wdata),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rdata),
      .empty   (q_empty)
   );

   smcd_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_page_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   smcd_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_data      (q_rdata),
      .q_pop       (q_pop),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata),
      .flush_done  (flush_done),
      .empty       (empty),
      .pop         (pop),
      .op          (rsp_op),
      .mem_address (rsp_mem_address),
      .mem_data    (rsp_mem_data),
      .dump_count  (rsp_dump_count),
      .reply_valid (rsp_reply_valid),
      .reply_byte  (rsp_reply_byte),
      .last        (rsp_last)
   );

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into a full queue");

   a_flush_done_pending : assert property (@(posedge clock) disable iff (reset)
      flush_done |-> flush_pend)
      else $error("flush finished with none pending");

   a_reply_ops : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_reply_valid) |-> (rsp_op == OP_NONE || rsp_op == OP_PAGE_WRITE))
      else $error("reply attached to an unexpected operation");

   a_invalid_last : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_op == OP_INVALID) |-> rsp_last)
      else $error("invalid command result not marked last");

endmodule

FILE: rtl/smcd_ram.sv
module smcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/smcd_fifo.sv
module smcd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  smcd_pkg::job_type wr_data,
   output logic              full,
   input  logic              pop,
   output smcd_pkg::job_type rd_data,
   output logic              empty
);

   import smcd_pkg::*;

   localparam int QW = $clog2(QUEUE_DEPTH);

   job_type       entries_ff [QUEUE_DEPTH];
   logic [QW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == (QW+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/smcd_front.sv
module smcd_front #(
   parameter int PAGE_BYTES = 64,
   localparam int IW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [7:0]        rx_byte,
   input  logic [7:0]        rx_backlog,
   input  logic [15:0]       erase_key,
   input  logic              q_full,
   output logic              q_push,
   output smcd_pkg::job_type q_data,
   output logic              ram_we,
   output logic [IW-1:0]     ram_waddr,
   output logic [7:0]        ram_wdata,
   input  logic              flush_done,
   output logic              flush_pend
);

   import smcd_pkg::*;

   localparam int FW = $clog2(PAGE_BYTES + 1);
   localparam logic [IW-1:0] PAGE_LAST = IW'(PAGE_BYTES - 1);

   // floor(a / PAGE_BYTES) == (a * RECIP) >> RECIP_SHIFT for every 16-bit a
   localparam int          RECIP_SHIFT = 16 + IW;
   localparam logic [16:0] RECIP       =
      17'(((64'd1 << RECIP_SHIFT) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));

   localparam logic [2:0] F_IDLE    = 3'd0;
   localparam logic [2:0] F_ADDR_HI = 3'd1;
   localparam logic [2:0] F_ADDR_LO = 3'd2;
   localparam logic [2:0] F_CNT_HI  = 3'd3;
   localparam logic [2:0] F_CNT_LO  = 3'd4;
   localparam logic [2:0] F_LOAD    = 3'd5;

   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_READ  = 3'd1;
   localparam logic [2:0] CMD_WRITE = 3'd2;
   localparam logic [2:0] CMD_LOAD  = 3'd3;
   localparam logic [2:0] CMD_DUMP  = 3'd4;
   localparam logic [2:0] CMD_ERASE = 3'd5;

   localparam logic [7:0] CHAR_READ  = 8'h72;
   localparam logic [7:0] CHAR_WRITE = 8'h77;
   localparam logic [7:0] CHAR_LOAD  = 8'h6C;
   localparam logic [7:0] CHAR_DUMP  = 8'h64;
   localparam logic [7:0] CHAR_ERASE = 8'h65;

   logic [2:0]    state_ff, state_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [15:0]   addr_ff, addr_in;
   logic [7:0]    cnt_hi_ff, cnt_hi_in;
   logic [15:0]   rem_ff, rem_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [IW-1:0] off_ff, off_in;
   logic          flush_pend_ff, flush_pend_in;
   logic [15:0]   quot_ff, quot_in;
   logic          mod_pend_ff, mod_pend_in;

   logic          accept;
   logic          flush_set;
   logic          done;
   logic          flush;
   logic [32:0]   recip_prod;
   logic [FW-1:0] fill_new;
   logic [15:0]   full_addr;
   logic [15:0]   count_word;

   assign full       = q_full || flush_pend_ff;
   assign accept     = push && !full;
   assign full_addr  = {addr_ff[15:8], rx_byte};
   assign count_word = {cnt_hi_ff, rx_byte};
   assign recip_prod = 33'(full_addr) * 33'(RECIP);
   assign done       = (rem_ff == 16'd1);
   assign fill_new   = (fill_ff < FW'(PAGE_BYTES)) ? fill_ff + 1'b1 : fill_ff;
   assign flush      = (off_ff == PAGE_LAST) || (addr_ff == 16'hFFFF) || done;
   assign flush_pend = flush_pend_ff;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      addr_in     = addr_ff;
      cnt_hi_in   = cnt_hi_ff;
      rem_in      = rem_ff;
      fill_in     = fill_ff;
      off_in      = off_ff;
      quot_in     = quot_ff;
      mod_pend_in = 1'b0;
      flush_set   = 1'b0;
      q_push      = 1'b0;
      q_data      = '0;
      ram_we      = 1'b0;
      ram_waddr   = off_ff;
      ram_wdata   = rx_byte;

      // Page offset of the load start address: address less quotient times page
      if (mod_pend_ff) begin
         off_in = IW'(addr_ff - quot_ff * 16'(PAGE_BYTES));
      end

      if (accept) begin
         unique case (state_ff)
            F_IDLE: begin
               state_in = F_ADDR_HI;
               unique case (rx_byte)
                  CHAR_READ:  cmd_in = CMD_READ;
                  CHAR_WRITE: cmd_in = CMD_WRITE;
                  CHAR_LOAD:  cmd_in = CMD_LOAD;
                  CHAR_DUMP:  cmd_in = CMD_DUMP;
                  CHAR_ERASE: cmd_in = CMD_ERASE;
                  default: begin
                     state_in    = F_IDLE;
                     cmd_in      = CMD_NONE;
                     q_push      = 1'b1;
                     q_data.job  = JOB_SINGLE;
                     q_data.op   = OP_INVALID;
                     q_data.data = rx_byte;
                  end
               endcase
            end
            F_ADDR_HI: begin
               addr_in  = {rx_byte, 8'h00};
               state_in = F_ADDR_LO;
            end
            F_ADDR_LO: begin
               addr_in = full_addr;
               unique case (cmd_ff)
                  CMD_READ: begin
                     q_push         = 1'b1;
                     q_data.job     = JOB_SINGLE;
                     q_data.op      = OP_READ;
                     q_data.address = full_addr;
                     state_in       = F_IDLE;
                     cmd_in         = CMD_NONE;
                  end
                  CMD_ERASE: begin
                     q_push = 1'b1;
                     if (full_addr != erase_key) begin
                        q_data.job   = JOB_SINGLE;
                        q_data.op    = OP_NONE;
                        q_data.reply = 8'd0;
                     end else begin
                        q_data.job   = JOB_PAIR;
                        q_data.op    = OP_ERASE;
                        q_data.reply = 8'd1;
                     end
                     state_in = F_IDLE;
                     cmd_in   = CMD_NONE;
                  end
                  default: begin
                     state_in = F_CNT_HI;
                     if (cmd_ff == CMD_LOAD) begin
                        quot_in     = 16'(recip_prod >> RECIP_SHIFT);
                        mod_pend_in = 1'b1;
                     end
                  end
               endcase
            end
            F_CNT_HI: begin
               cnt_hi_in = rx_byte;
               if (cmd_ff == CMD_WRITE) begin
                  q_push         = 1'b1;
                  q_data.job     = JOB_PAIR;
                  q_data.op      = OP_WRITE;
                  q_data.address = addr_ff;
                  q_data.data    = rx_byte;
                  q_data.reply   = rx_backlog;
                  state_in       = F_IDLE;
                  cmd_in         = CMD_NONE;
               end else begin
                  state_in = F_CNT_LO;
               end
            end
            F_CNT_LO: begin
               if (cmd_ff == CMD_DUMP) begin
                  q_push         = 1'b1;
                  q_data.job     = JOB_SINGLE;
                  q_data.op      = OP_DUMP;
                  q_data.address = addr_ff;
                  q_data.count   = count_word;
                  state_in       = F_IDLE;
                  cmd_in         = CMD_NONE;
               end else if (cmd_ff == CMD_LOAD) begin
                  // a zero count still takes one byte
                  rem_in   = (count_word == '0) ? 16'd1 : count_word;
                  fill_in  = '0;
                  state_in = F_LOAD;
               end else begin
                  state_in = F_IDLE;
                  cmd_in   = CMD_NONE;
               end
            end
            F_LOAD: begin
               ram_we  = 1'b1;
               q_push  = 1'b1;
               rem_in  = rem_ff - 1'b1;
               if (flush) begin
                  flush_set      = 1'b1;
                  q_data.job     = JOB_FLUSH;
                  q_data.op      = OP_PAGE_WRITE;
                  q_data.address = addr_ff + 16'd1 - 16'(fill_new);
                  q_data.data    = 8'(IW'(off_ff + 1'b1 - IW'(fill_new)));
                  q_data.count   = 16'(fill_new);
                  q_data.reply   = rx_backlog;
                  fill_in        = '0;
               end else begin
                  q_data.job   = JOB_SINGLE;
                  q_data.op    = OP_NONE;
                  q_data.reply = rx_backlog;
                  fill_in      = fill_new;
               end
               if (done) begin
                  state_in = F_IDLE;
                  cmd_in   = CMD_NONE;
                  fill_in  = '0;
               end else begin
                  addr_in = addr_ff + 16'd1;
                  off_in  = ((off_ff == PAGE_LAST) || (addr_ff == 16'hFFFF)) ?
                            '0 : off_ff + 1'b1;
               end
            end
            default: begin
               state_in = F_IDLE;
               cmd_in   = CMD_NONE;
            end
         endcase
      end

      flush_pend_in = (flush_pend_ff && !flush_done) || flush_set;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         cmd_ff        <= CMD_NONE;
         fill_ff       <= '0;
         flush_pend_ff <= 1'b0;
         mod_pend_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cmd_ff        <= cmd_in;
         fill_ff       <= fill_in;
         flush_pend_ff <= flush_pend_in;
         mod_pend_ff   <= mod_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      cnt_hi_ff <= cnt_hi_in;
      rem_ff    <= rem_in;
      off_ff    <= off_in;
      quot_ff   <= quot_in;
   end

endmodule

FILE: rtl/smcd_back.sv
module smcd_back #(
   parameter int PAGE_BYTES = 64,
   localparam int IW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  smcd_pkg::job_type q_data,
   output logic              q_pop,
   output logic              ram_re,
   output logic [IW-1:0]     ram_raddr,
   input  logic [7:0]        ram_rdata,
   output logic              flush_done,
   output logic              empty,
   input  logic              pop,
   output logic [2:0]        op,
   output logic [15:0]       mem_address,
   output logic [7:0]        mem_data,
   output logic [15:0]       dump_count,
   output logic              reply_valid,
   output logic [7:0]        reply_byte,
   output logic              last
);

   import smcd_pkg::*;

   localparam int FW = $clog2(PAGE_BYTES + 1);

   localparam logic [1:0] B_IDLE    = 2'd0;
   localparam logic [1:0] B_SECOND  = 2'd1;
   localparam logic [1:0] B_FL_READ = 2'd2;
   localparam logic [1:0] B_FL_LOAD = 2'd3;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] address;
      logic [7:0]  data;
      logic [15:0] count;
      logic        reply_valid;
      logic [7:0]  reply_byte;
      logic        last;
   } rsp_type;

   logic [1:0]    state_ff, state_in;
   job_type       job_ff, job_in;
   logic [FW-1:0] idx_ff, idx_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff, out_in;

   logic          out_free;
   logic          out_load;
   logic          first_byte;
   logic          last_byte;

   assign out_free   = !out_valid_ff || pop;
   assign first_byte = (idx_ff == '0);
   assign last_byte  = (FW'(idx_ff + 1'b1) == job_ff.count[FW-1:0]);

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      idx_in     = idx_ff;
      out_in     = out_ff;
      out_load   = 1'b0;
      q_pop      = 1'b0;
      ram_re     = 1'b0;
      ram_raddr  = IW'(job_ff.data[IW-1:0] + IW'(idx_ff));
      flush_done = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop  = 1'b1;
               job_in = q_data;
               idx_in = '0;
               unique case (q_data.job)
                  JOB_SINGLE: begin
                     out_load           = 1'b1;
                     out_in.op          = q_data.op;
                     out_in.address     = q_data.address;
                     out_in.data        = q_data.data;
                     out_in.count       = q_data.count;
                     out_in.reply_valid = (q_data.op == OP_NONE);
                     out_in.reply_byte  = q_data.reply;
                     out_in.last        = 1'b1;
                  end
                  JOB_PAIR: begin
                     out_load           = 1'b1;
                     out_in.op          = q_data.op;
                     out_in.address     = q_data.address;
                     out_in.data        = q_data.data;
                     out_in.count       = q_data.count;
                     out_in.reply_valid = 1'b0;
                     out_in.reply_byte  = 8'd0;
                     out_in.last        = 1'b0;
                     state_in           = B_SECOND;
                  end
                  JOB_FLUSH: begin
                     state_in = B_FL_READ;
                  end
                  default: begin
                     state_in = B_IDLE;
                  end
               endcase
            end
         end
         B_SECOND: begin
            // trailing reply after the write or erase
            if (out_free) begin
               out_load           = 1'b1;
               out_in.op          = OP_NONE;
               out_in.address     = 16'd0;
               out_in.data        = 8'd0;
               out_in.count       = 16'd0;
               out_in.reply_valid = 1'b1;
               out_in.reply_byte  = job_ff.reply;
               out_in.last        = 1'b1;
               state_in           = B_IDLE;
            end
         end
         B_FL_READ: begin
            ram_re   = 1'b1;
            state_in = B_FL_LOAD;
         end
         B_FL_LOAD: begin
            // read data holds until the next read, so wait here on a stall
            if (out_free) begin
               out_load           = 1'b1;
               out_in.op          = OP_PAGE_WRITE;
               out_in.address     = job_ff.address + 16'(idx_ff);
               out_in.data        = ram_rdata;
               out_in.count       = 16'd0;
               out_in.reply_valid = first_byte;
               out_in.reply_byte  = first_byte ? job_ff.reply : 8'd0;
               out_in.last        = last_byte;
               idx_in             = FW'(idx_ff + 1'b1);
               if (last_byte) begin
                  flush_done = 1'b1;
                  state_in   = B_IDLE;
               end else begin
                  state_in = B_FL_READ;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      out_valid_in = out_load || (out_valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      out_ff <= out_in;
   end

   assign empty       = !out_valid_ff;
   assign op          = out_ff.op;
   assign mem_address = out_ff.address;
   assign mem_data    = out_ff.data;
   assign dump_count  = out_ff.count;
   assign reply_valid = out_ff.reply_valid;
   assign reply_byte  = out_ff.reply_byte;
   assign last        = out_ff.last;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import smcd_pkg::*;

   localparam int PAGE_BYTES = 64;
   localparam int RESET_CYCLES = 10;
   localparam int SETTLE_CYCLES = 300;
   localparam int IDLE_LIMIT = 3000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int LONG_HOLD_AFTER = 30;
   localparam int RANDOM_ITEMS = 25;
   localparam logic [2:0] ERASE_KEY_ADDR = 3'd0;
   localparam logic [15:0] ERASE_KEY_RESET = 16'hBEEF;

   localparam logic [7:0] LETTER_READ = "r";
   localparam logic [7:0] LETTER_WRITE = "w";
   localparam logic [7:0] LETTER_LOAD = "l";
   localparam logic [7:0] LETTER_DUMP = "d";
   localparam logic [7:0] LETTER_ERASE = "e";

   typedef enum logic [1:0] {PARSE_IDLE, PARSE_ADDRESS, PARSE_PARAM} parse_phase_type;
   typedef enum logic [2:0] {
      CMD_NONE, CMD_READ, CMD_WRITE, CMD_LOAD, CMD_DUMP, CMD_ERASE
   } command_type;

   typedef struct {
      logic [7:0] rx_byte;
      logic [7:0] backlog;
   } host_byte_type;

   typedef struct {
      logic [2:0]  op;
      logic [15:0] address;
      logic [7:0]  data;
      logic [15:0] count;
      logic        reply_valid;
      logic [7:0]  reply;
      logic        last;
   } mem_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_rx_byte = 8'h00;
   logic [7:0]  req_rx_backlog = 8'h00;
   logic        empty;
   logic        pop = 1'b0;
   logic [2:0]  rsp_op;
   logic [15:0] rsp_mem_address;
   logic [7:0]  rsp_mem_data;
   logic [15:0] rsp_dump_count;
   logic        rsp_reply_valid;
   logic [7:0]  rsp_reply_byte;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   host_byte_type  host_bytes[$];
   mem_result_type awaited_results[$];

   int mismatches = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   bit activity = 0;
   bit byte_taken = 0;

   // sender and receiver pacing
   int burst_left = 8;
   int gap_left = 0;
   int run_left = 0;
   int stall_left = 0;
   int long_hold_left = 0;
   bit long_hold_done = 0;

   // decoder state as seen by the predictor
   parse_phase_type parse_phase;
   command_type     command_kind;
   logic [16:0]     byte_pos;
   logic [15:0]     cur_addr;
   logic [15:0]     count_val;
   logic [7:0]      page_buf[PAGE_BYTES];
   int              page_fill;
   logic [15:0]     erase_key;

   serial_memory_command_decoder_core #(.PAGE_BYTES(PAGE_BYTES)) DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_rx_byte(req_rx_byte),
      .req_rx_backlog(req_rx_backlog),
      .empty(empty),
      .pop(pop),
      .rsp_op(rsp_op),
      .rsp_mem_address(rsp_mem_address),
      .rsp_mem_data(rsp_mem_data),
      .rsp_dump_count(rsp_dump_count),
      .rsp_reply_valid(rsp_reply_valid),
      .rsp_reply_byte(rsp_reply_byte),
      .rsp_last(rsp_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void return_to_idle();
      parse_phase = PARSE_IDLE;
      command_kind = CMD_NONE;
      byte_pos = '0;
      cur_addr = '0;
      count_val = '0;
      page_fill = 0;
   endfunction

   function automatic void expect_result(logic [2:0] op, logic [15:0] address,
                                         logic [7:0] data, logic [15:0] count,
                                         logic reply_valid, logic [7:0] reply);
      awaited_results.push_back('{op, address, data, count, reply_valid, reply, 1'b0});
   endfunction

   function automatic void decode_host_byte(logic [7:0] b, logic [7:0] backlog);
      int first;
      int offset;
      int i;
      bit done;
      logic [15:0] start;
      logic [15:0] a;
      command_type letter_cmd;
      first = awaited_results.size();
      case (parse_phase)
         PARSE_ADDRESS: begin
            if (byte_pos == 0) begin
               cur_addr = {b, 8'h00};
               byte_pos = 17'd1;
            end else begin
               cur_addr = cur_addr | {8'h00, b};
               byte_pos = 17'd2;
               if (command_kind == CMD_READ) begin
                  expect_result(OP_READ, cur_addr, 8'h00, 16'h0000, 1'b0, 8'h00);
                  return_to_idle();
               end else if (command_kind == CMD_ERASE) begin
                  if (cur_addr != erase_key) begin
                     expect_result(OP_NONE, 16'h0000, 8'h00, 16'h0000, 1'b1, 8'h00);
                  end else begin
                     expect_result(OP_ERASE, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h00);
                     expect_result(OP_NONE, 16'h0000, 8'h00, 16'h0000, 1'b1, 8'h01);
                  end
                  return_to_idle();
               end else begin
                  parse_phase = PARSE_PARAM;
               end
            end
         end
         PARSE_PARAM: begin
            if (byte_pos <= 2) begin
               count_val = {8'h00, b};
               byte_pos = 17'd3;
               if (command_kind == CMD_WRITE) begin
                  expect_result(OP_WRITE, cur_addr, b, 16'h0000, 1'b0, 8'h00);
                  expect_result(OP_NONE, 16'h0000, 8'h00, 16'h0000, 1'b1, backlog);
                  return_to_idle();
               end
            end else if (byte_pos == 3) begin
               count_val = {count_val[7:0], b};
               byte_pos = 17'd4;
               if (command_kind == CMD_DUMP) begin
                  expect_result(OP_DUMP, cur_addr, 8'h00, count_val, 1'b0, 8'h00);
                  return_to_idle();
               end else if (command_kind != CMD_LOAD) begin
                  return_to_idle();
               end
            end else if (command_kind == CMD_LOAD) begin
               offset = cur_addr % PAGE_BYTES;
               page_buf[offset] = b;
               if (page_fill < PAGE_BYTES) page_fill++;
               byte_pos = byte_pos + 17'd1;
               done = (byte_pos >= count_val + 17'd4);
               if (offset == PAGE_BYTES - 1 || cur_addr == 16'hFFFF || done) begin
                  // flush the gathered run; the ack rides on its first item
                  start = cur_addr + 16'd1 - 16'(page_fill);
                  for (i = 0; i < page_fill; i++) begin
                     a = start + 16'(i);
                     expect_result(OP_PAGE_WRITE, a, page_buf[a % PAGE_BYTES], 16'h0000,
                                   i == 0, (i == 0) ? backlog : 8'h00);
                  end
                  page_fill = 0;
               end else begin
                  expect_result(OP_NONE, 16'h0000, 8'h00, 16'h0000, 1'b1, backlog);
               end
               if (done) return_to_idle();
               else cur_addr = cur_addr + 16'd1;
            end else begin
               return_to_idle();
            end
         end
         default: begin
            case (b)
               LETTER_READ:  letter_cmd = CMD_READ;
               LETTER_WRITE: letter_cmd = CMD_WRITE;
               LETTER_LOAD:  letter_cmd = CMD_LOAD;
               LETTER_DUMP:  letter_cmd = CMD_DUMP;
               LETTER_ERASE: letter_cmd = CMD_ERASE;
               default:      letter_cmd = CMD_NONE;
            endcase
            if (letter_cmd == CMD_NONE) begin
               expect_result(OP_INVALID, 16'h0000, b, 16'h0000, 1'b0, 8'h00);
               return_to_idle();
            end else begin
               command_kind = letter_cmd;
               parse_phase = PARSE_ADDRESS;
            end
         end
      endcase
      if (awaited_results.size() > first)
         awaited_results[awaited_results.size() - 1].last = 1'b1;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // stimulus builders
   function automatic void queue_item(logic [7:0] b, logic [7:0] backlog);
      host_bytes.push_back('{b, backlog});
   endfunction

   function automatic void queue_byte(logic [7:0] b);
      queue_item(b, 8'($urandom_range(0, 255)));
   endfunction

   function automatic void queue_word(logic [15:0] w);
      queue_byte(w[15:8]);
      queue_byte(w[7:0]);
   endfunction

   function automatic logic [7:0] pick_letter();
      case ($urandom_range(0, 4))
         0: return LETTER_READ;
         1: return LETTER_WRITE;
         2: return LETTER_LOAD;
         3: return LETTER_DUMP;
         default: return LETTER_ERASE;
      endcase
   endfunction

   function automatic int queue_load(logic [15:0] address, int count);
      int n;
      int data_bytes;
      data_bytes = (count == 0) ? 1 : count;
      queue_byte(LETTER_LOAD);
      queue_word(address);
      queue_word(16'(count));
      for (n = 0; n < data_bytes; n++) queue_byte(8'($urandom_range(0, 255)));
      return 5 + data_bytes;
   endfunction

   function automatic void queue_directed();
      int unused;
      queue_byte(LETTER_ERASE);
      queue_word(ERASE_KEY_RESET);
      queue_byte(LETTER_ERASE);
      queue_word(16'h0000);
      queue_item(LETTER_WRITE, 8'h00);
      queue_item(8'hFF, 8'h00);
      queue_item(8'hFF, 8'h00);
      queue_item(8'hFF, 8'hFF);
      // dump near the top of the address space, with a zero count
      queue_byte(LETTER_DUMP);
      queue_word(16'hFFF0);
      queue_word(16'h0000);
      queue_item(8'hFF, 8'hFF);
      queue_item(8'h00, 8'h00);
      unused = queue_load(16'h1234, 0);
      // crosses 0xFFFF and wraps to 0
      unused = queue_load(16'hFFFE, 3);
   endfunction

   function automatic void queue_random(int target, logic [15:0] key);
      int queued;
      int pick;
      int count;
      logic [15:0] address;
      queued = 0;
      while (queued < target) begin
         pick = $urandom_range(0, 99);
         address = 16'($urandom_range(0, 65535));
         if (pick < 8) begin
            queue_byte(8'($urandom_range(0, 255)));
            queued += 1;
         end else if (pick < 12) begin
            // command cut short: the next command is eaten as its address
            queue_byte(pick_letter());
            queue_byte(address[15:8]);
            queued += 2;
         end else if (pick < 28) begin
            queue_byte(LETTER_READ);
            queue_word(address);
            queued += 3;
         end else if (pick < 44) begin
            queue_byte(LETTER_WRITE);
            queue_word(address);
            queue_byte(8'($urandom_range(0, 255)));
            queued += 4;
         end else if (pick < 56) begin
            queue_byte(LETTER_DUMP);
            queue_word(address);
            queue_word(16'($urandom_range(0, 65535)));
            queued += 5;
         end else if (pick < 70) begin
            queue_byte(LETTER_ERASE);
            queue_word(($urandom_range(0, 1) == 0) ? key : address);
            queued += 3;
         end else begin
            count = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            queued += queue_load(address, count);
         end
      end
   endfunction

   task automatic write_erase_key(input logic [15:0] key);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ERASE_KEY_ADDR;
      pwdata <= {16'h0000, key};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      erase_key = key;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // wait until every item is taken and every result is back, then let the block go quiet
   task automatic settle();
      while (host_bytes.size() != 0 || awaited_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      int round;
      logic [15:0] key;
      return_to_idle();
      erase_key = ERASE_KEY_RESET;
      for (round = 0; round < PAGE_BYTES; round++) page_buf[round] = 8'h00;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      queue_directed();
      settle();

      for (round = 0; round < 3; round++) begin
         if (round == 0) key = 16'h0000;
         else if (round == 1) key = 16'hFFFF;
         else key = 16'($urandom_range(0, 65535));
         write_erase_key(key);
         queue_random(RANDOM_ITEMS, key);
         settle();
      end

      write_erase_key(ERASE_KEY_RESET);
      queue_byte(LETTER_ERASE);
      queue_word(ERASE_KEY_RESET);
      settle();

      if (mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // sender: bursts of items with random gaps
   always @(negedge clock) begin : byte_sender
      bit taken;
      taken = byte_taken;
      byte_taken = 0;
      if (taken) begin
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         end
      end
      if (reset) begin
         push <= 1'b0;
      end else if (taken || !push) begin
         if (gap_left > 0) begin
            push <= 1'b0;
            gap_left--;
         end else if (host_bytes.size() > 0) begin
            push <= 1'b1;
            req_rx_byte <= host_bytes[0].rx_byte;
            req_rx_backlog <= host_bytes[0].backlog;
         end else begin
            push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && push && !full) begin
         activity = 1;
         byte_taken = 1;
         void'(host_bytes.pop_front());
         decode_host_byte(req_rx_byte, req_rx_backlog);
      end
   end

   // receiver: runs of pops broken by short stalls, and one long hold-off
   always @(negedge clock) begin : result_receiver
      if (reset) begin
         pop <= 1'b0;
      end else if (long_hold_left > 0) begin
         pop <= 1'b0;
         long_hold_left--;
      end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
         long_hold_done = 1;
         long_hold_left = LONG_HOLD_CYCLES - 1;
         pop <= 1'b0;
      end else if (stall_left > 0) begin
         pop <= 1'b0;
         stall_left--;
      end else if (run_left > 0) begin
         pop <= 1'b1;
         run_left--;
      end else begin
         run_left = $urandom_range(1, 30);
         stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else begin
            pop <= 1'b1;
            run_left--;
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      mem_result_type want;
      if (!reset && pop && !empty) begin
         activity = 1;
         results_seen++;
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got op %0d address %0h",
                     $time, rsp_op, rsp_mem_address);
            mismatches++;
         end else begin
            want = awaited_results.pop_front();
            check_field("op", 16'(want.op), 16'(rsp_op));
            check_field("mem_address", want.address, rsp_mem_address);
            check_field("mem_data", 16'(want.data), 16'(rsp_mem_data));
            check_field("dump_count", want.count, rsp_dump_count);
            check_field("reply_valid", 16'(want.reply_valid), 16'(rsp_reply_valid));
            check_field("reply_byte", 16'(want.reply), 16'(rsp_reply_byte));
            check_field("last", 16'(want.last), 16'(rsp_last));
         end
      end
   end

   // end the run when nothing moves for too long
   always @(negedge clock) begin
      if (activity) idle_cycles = 0;
      else idle_cycles++;
      activity = 0;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

endmodule
